FILE: hw/rtl/ansi_sgr_color_parser_defines.svh
// Assertion macros used by the top level of the colour parser RTL.
`ifndef ANSI_SGR_COLOR_PARSER_DEFINES_SVH
`define ANSI_SGR_COLOR_PARSER_DEFINES_SVH

// The condition must never hold at a clock edge outside reset.
`define ASGR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/asgr_pkg.sv
// Types, character codes and the SGR colour function of the colour parser.
package asgr_pkg;

  typedef enum logic [2:0] {
    ST_TEXT    = 3'd0,
    ST_ESC     = 3'd1,
    ST_CSI     = 3'd2,
    ST_PARAM   = 3'd3,
    ST_BRACKET = 3'd4,
    ST_QUERY   = 3'd5,
    ST_PRIVATE = 3'd6
  } parse_state_t;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_VT  = 8'h0B;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_CAN = 8'h18;
  localparam logic [7:0] BYTE_SUB = 8'h1A;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_DEL = 8'h7F;
  localparam logic [7:0] BYTE_CSI = 8'h9B;

  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_EQ       = 8'h3D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_QUERY    = 8'h3F;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_J        = 8'h4A;
  localparam logic [7:0] CH_K        = 8'h4B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;

  localparam logic [7:0] SGR_RESET   = 8'd0;
  localparam logic [7:0] SGR_BOLD    = 8'd1;
  localparam logic [7:0] SGR_FG_BASE = 8'd30;
  localparam logic [7:0] SGR_BG_BASE = 8'd40;
  localparam logic [7:0] PARAM_MAX   = 8'd255;

  localparam logic [4:0] FG_DEFAULT = 5'd7;
  localparam logic [7:0] BG_DEFAULT = 8'd0;
  localparam logic [4:0] FG_BOLD    = 5'd8;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_ATTR = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic [4:0] fg;
    logic [7:0] bg;
  } colour_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [4:0] fg_color;
    logic [7:0] bg_color;
    logic       fg_nondefault;
    logic       bg_nondefault;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] push_n;
    result_t    res0;
    result_t    res1;
  } push_t;

  typedef struct packed {
    logic               room;
    logic [FIFO_CW-1:0] count;
  } fifo_status_t;

  function automatic colour_t sgr_apply(logic [7:0] x, colour_t committed);
    colour_t    r;
    logic [7:0] diff;
    r    = committed;
    diff = x - SGR_FG_BASE;
    if (x == SGR_RESET) begin
      r.fg = FG_DEFAULT;
      r.bg = BG_DEFAULT;
    end else if (x == SGR_BOLD) begin
      r.fg = committed.fg | FG_BOLD;
    end else if (x >= SGR_BG_BASE) begin
      r.bg = x - SGR_BG_BASE;
    end else if (x >= SGR_FG_BASE) begin
      r.fg = ((|committed.fg[4:3]) ? FG_BOLD : 5'd0) + diff[4:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ansi_sgr_color_parser.sv
// Top level of the ANSI SGR colour parser.
//
// Terminal output enters one byte per transaction on the in_valid/in_ready
// channel. Results leave one per transaction on the out_valid/out_ready
// channel with the fields kind, out_byte, fg_color, bg_color, fg_nondefault,
// bg_nondefault and last.
// A byte is accepted every cycle while the receiver keeps up. It is held in an
// input register and parsed as soon as the four-entry result queue has room for
// two results, when its results enter the queue; the first result is offered
// once it is registered in the queue. A byte that produces an attribute change
// and an echo gives two results. The output delivers one result per cycle while
// out_ready is high, so the input takes one byte per cycle while each byte gives at most one result.
// Escape, control and dropped bytes give no result.
// When the receiver stalls, the queue absorbs results until fewer than two
// entries are free; the input register then holds its byte and in_ready
// falls until space returns.
// Synchronous reset returns the parser to plain text with default colours
// (foreground 7, background 0) and empties the queue.
module ansi_sgr_color_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] out_byte,
  output logic [4:0] fg_color,
  output logic [7:0] bg_color,
  output logic       fg_nondefault,
  output logic       bg_nondefault,
  output logic       last
);
  import asgr_pkg::*;

  `include "ansi_sgr_color_parser_defines.svh"

  logic         byte_valid;
  logic [7:0]   byte_q;
  logic         step;
  logic         pop;
  push_t        push;
  result_t      head;
  fifo_status_t status;

  assign step     = byte_valid && status.room;
  assign in_ready = !byte_valid || step;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
    end
  end

  asgr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (byte_q),
    .push    (push)
  );

  asgr_out_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .valid  (out_valid),
    .status (status)
  );

  assign kind          = head.kind;
  assign out_byte      = head.out_byte;
  assign fg_color      = head.fg_color;
  assign bg_color      = head.bg_color;
  assign fg_nondefault = head.fg_nondefault;
  assign bg_nondefault = head.bg_nondefault;
  assign last          = head.last;

  `ASGR_ASSERT_NEVER(a_queue_bound, status.count > FIFO_CW'(FIFO_DEPTH), "result queue overflow")
  `ASGR_ASSERT_NEXT(a_pair_push, (push.push_n == 2'd2) && !pop, status.count == $past(status.count) + 3'd2, "result pair not queued")
  `ASGR_ASSERT_NEVER(a_attr_not_last, out_valid && (kind == KIND_ATTR) && last, "attribute change marked last")
  `ASGR_ASSERT_NEVER(a_step_no_room, (push.push_n != 2'd0) && !step, "results pushed without a parse step")

endmodule

FILE: hw/rtl/asgr_parser.sv
// Escape sequence parser with SGR colour state and result generation.
module asgr_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  output asgr_pkg::push_t   push
);
  import asgr_pkg::*;

  parse_state_t state, state_next;
  colour_t      committed, committed_next;
  colour_t      pending, pending_next;
  logic [7:0]   param_value, param_value_next;
  logic         change_outstanding, change_outstanding_next;

  logic         is_ctrl;
  logic         do_param;
  colour_t      work_pend;
  logic [7:0]   work_pv;
  logic [11:0]  acc;
  logic [7:0]   digit_sat;
  logic [7:0]   digit_off;

  always_comb begin
    is_ctrl = (byte_in == BYTE_CAN) || (byte_in == BYTE_SUB) || (byte_in == BYTE_ESC) ||
              (byte_in == BYTE_CSI) || (byte_in == BYTE_NUL) || (byte_in == BYTE_BEL) ||
              (byte_in == BYTE_VT) || (byte_in == BYTE_FF) || (byte_in == BYTE_CR) ||
              (byte_in == BYTE_DEL);
  end

  always_comb begin
    state_next              = state;
    committed_next          = committed;
    pending_next            = pending;
    param_value_next        = param_value;
    change_outstanding_next = change_outstanding;
    do_param                = 1'b0;
    work_pend               = pending;
    work_pv                 = param_value;
    digit_off               = byte_in - CH_ZERO;
    acc                     = '0;
    digit_sat               = '0;
    priority if ((byte_in == BYTE_CAN) || (byte_in == BYTE_SUB)) begin
      state_next = ST_TEXT;
    end else if (byte_in == BYTE_ESC) begin
      state_next = ST_ESC;
    end else if (byte_in == BYTE_CSI) begin
      state_next = ST_CSI;
    end else if (is_ctrl) begin
      state_next = state;
    end else begin
      unique case (state)
        ST_TEXT: begin
          change_outstanding_next = 1'b0;
        end
        ST_ESC: begin
          if (byte_in == CH_LBRACKET) begin
            state_next = ST_CSI;
          end else if ((byte_in == CH_EQ) || (byte_in == CH_GT) || (byte_in == CH_H)) begin
            state_next = ST_TEXT;
          end
        end
        ST_CSI: begin
          if ((byte_in == CH_K) || (byte_in == CH_H) || (byte_in == CH_J)) begin
            state_next = ST_TEXT;
          end else if (byte_in == CH_QUERY) begin
            state_next = ST_QUERY;
          end else begin
            do_param  = 1'b1;
            work_pend = sgr_apply(SGR_RESET, committed);
            work_pv   = SGR_RESET;
          end
        end
        ST_PARAM: begin
          do_param = 1'b1;
        end
        ST_QUERY: begin
          pending_next     = sgr_apply(byte_in, committed);
          param_value_next = byte_in;
          state_next       = ST_PRIVATE;
        end
        default: begin
          state_next = ST_TEXT;
        end
      endcase
      if (do_param) begin
        state_next       = ST_PARAM;
        pending_next     = work_pend;
        param_value_next = work_pv;
        acc              = {4'd0, work_pv} * 12'd10 + {4'd0, digit_off};
        digit_sat        = (acc > {4'd0, PARAM_MAX}) ? PARAM_MAX : acc[7:0];
        if (byte_in == CH_M) begin
          if (committed != work_pend) begin
            committed_next          = work_pend;
            param_value_next        = '0;
            change_outstanding_next = 1'b1;
          end
          state_next = ST_TEXT;
        end else if (byte_in == CH_LBRACKET) begin
          state_next = ST_BRACKET;
        end else if (byte_in == CH_SEMI) begin
          pending_next     = sgr_apply(SGR_RESET, committed);
          param_value_next = SGR_RESET;
        end else if ((byte_in >= CH_ZERO) && (byte_in <= CH_NINE)) begin
          pending_next     = sgr_apply(digit_sat, committed);
          param_value_next = digit_sat;
        end else begin
          state_next = ST_TEXT;
        end
      end
    end
  end

  always_comb begin
    result_t attr;
    result_t echo;
    attr               = '0;
    attr.kind          = KIND_ATTR;
    attr.fg_color      = pending.fg;
    attr.bg_color      = pending.bg;
    attr.fg_nondefault = (pending.fg != FG_DEFAULT);
    attr.bg_nondefault = (pending.bg != BG_DEFAULT);
    attr.last          = 1'b0;
    echo               = '0;
    echo.kind          = KIND_ECHO;
    echo.out_byte      = byte_in;
    echo.last          = 1'b1;
    push               = '0;
    if (step && !is_ctrl && (state == ST_TEXT)) begin
      if (change_outstanding) begin
        push.push_n = 2'd2;
        push.res0   = attr;
        push.res1   = echo;
      end else begin
        push.push_n = 2'd1;
        push.res0   = echo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_TEXT;
      committed          <= '{fg: FG_DEFAULT, bg: BG_DEFAULT};
      pending            <= '{fg: FG_DEFAULT, bg: BG_DEFAULT};
      param_value        <= '0;
      change_outstanding <= 1'b0;
    end else if (step) begin
      state              <= state_next;
      committed          <= committed_next;
      pending            <= pending_next;
      param_value        <= param_value_next;
      change_outstanding <= change_outstanding_next;
    end
  end

endmodule

FILE: hw/rtl/asgr_out_fifo.sv
// Result queue that takes up to two results a cycle and delivers one.
module asgr_out_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  asgr_pkg::push_t        push,
  input  logic                   pop,
  output asgr_pkg::result_t      head,
  output logic                   valid,
  output asgr_pkg::fifo_status_t status
);
  import asgr_pkg::*;

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   count, count_next;
  logic [FIFO_AW-1:0]   wr_ptr_inc;

  assign wr_ptr_inc    = wr_ptr + {{(FIFO_AW-1){1'b0}}, 1'b1};
  assign count_next    = count + {{(FIFO_CW-2){1'b0}}, push.push_n}
                         - {{(FIFO_CW-1){1'b0}}, pop};
  assign valid         = (count != '0);
  assign head          = mem[rd_ptr];
  assign status.count  = count;
  assign status.room   = (count <= FIFO_CW'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.push_n != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.push_n == 2'd2) begin
      mem[wr_ptr_inc] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.push_n[FIFO_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + {{(FIFO_AW-1){1'b0}}, 1'b1};
      end
      count <= count_next;
    end
  end

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the ANSI SGR colour parser, with a scoreboard that predicts results.
`timescale 1ns / 100ps

import asgr_pkg::*;

class colour_scoreboard;
  parse_state_t parse_st;
  logic [4:0] committed_fg, pending_fg;
  logic [7:0] committed_bg, pending_bg, param_value;
  logic change_due;
  result_t expected_q[$];
  int errors, bytes_seen, results_seen, attr_seen;

  function new();
    parse_st = ST_TEXT;
    committed_fg = FG_DEFAULT;
    committed_bg = BG_DEFAULT;
    pending_fg = FG_DEFAULT;
    pending_bg = BG_DEFAULT;
    param_value = 8'd0;
    change_due = 1'b0;
    errors = 0;
    bytes_seen = 0;
    results_seen = 0;
    attr_seen = 0;
  endfunction

  function int pending_count();
    return expected_q.size();
  endfunction

  function void queue_result(logic kind_v, logic [7:0] echo_v, logic [4:0] fg_v,
                             logic [7:0] bg_v, logic last_v);
    result_t r;
    r.kind = kind_v;
    r.out_byte = echo_v;
    r.fg_color = fg_v;
    r.bg_color = bg_v;
    r.fg_nondefault = (kind_v == KIND_ATTR) && (fg_v != FG_DEFAULT);
    r.bg_nondefault = (kind_v == KIND_ATTR) && (bg_v != BG_DEFAULT);
    r.last = last_v;
    expected_q.push_back(r);
  endfunction

  // Every parameter starts again from the committed colours.
  function void select_colours(int x);
    int fg, bg;
    fg = int'(committed_fg);
    bg = int'(committed_bg);
    if (x == int'(SGR_RESET)) begin
      fg = int'(FG_DEFAULT);
      bg = int'(BG_DEFAULT);
    end else if (x == int'(SGR_BOLD)) begin
      fg = fg | int'(FG_BOLD);
    end else if (x >= int'(SGR_BG_BASE)) begin
      bg = x - int'(SGR_BG_BASE);
    end else if (x >= int'(SGR_FG_BASE)) begin
      fg = (fg >= int'(FG_BOLD) ? int'(FG_BOLD) : 0) + x - int'(SGR_FG_BASE);
    end
    pending_fg = 5'(fg);
    pending_bg = 8'(bg);
    param_value = 8'(x);
  endfunction

  function void take_param_byte(logic [7:0] b);
    int v;
    if (b == CH_M) begin
      if (committed_fg != pending_fg || committed_bg != pending_bg) begin
        committed_fg = pending_fg;
        committed_bg = pending_bg;
        param_value = 8'd0;
        change_due = 1'b1;
      end
      parse_st = ST_TEXT;
    end else if (b == CH_LBRACKET) begin
      parse_st = ST_BRACKET;
    end else if (b == CH_SEMI) begin
      select_colours(int'(SGR_RESET));
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      v = int'(param_value) * 10 + int'(b) - int'(CH_ZERO);
      if (v > int'(PARAM_MAX)) v = int'(PARAM_MAX);
      select_colours(v);
    end else begin
      parse_st = ST_TEXT;
    end
  endfunction

  function void advance(logic [7:0] b);
    case (parse_st)
      ST_TEXT: begin
        if (change_due) begin
          queue_result(KIND_ATTR, 8'd0, pending_fg, pending_bg, 1'b0);
          change_due = 1'b0;
        end
        queue_result(KIND_ECHO, b, 5'd0, 8'd0, 1'b1);
      end
      ST_ESC: begin
        if (b == CH_LBRACKET) parse_st = ST_CSI;
        else if (b == CH_EQ || b == CH_GT || b == CH_H) parse_st = ST_TEXT;
      end
      ST_CSI: begin
        if (b == CH_K || b == CH_H || b == CH_J) begin
          parse_st = ST_TEXT;
        end else if (b == CH_QUERY) begin
          parse_st = ST_QUERY;
        end else begin
          select_colours(int'(SGR_RESET));
          parse_st = ST_PARAM;
          take_param_byte(b);
        end
      end
      ST_PARAM: take_param_byte(b);
      ST_QUERY: begin
        select_colours(int'(b));
        parse_st = ST_PRIVATE;
      end
      default: parse_st = ST_TEXT;
    endcase
  endfunction

  function void note_byte(logic [7:0] b);
    bytes_seen++;
    if (b == BYTE_CAN || b == BYTE_SUB) begin
      parse_st = ST_TEXT;
    end else if (b == BYTE_ESC) begin
      parse_st = ST_ESC;
    end else if (b == BYTE_CSI) begin
      parse_st = ST_CSI;
    end else if (!(b == BYTE_NUL || b == BYTE_BEL || b == BYTE_VT || b == BYTE_FF ||
                   b == BYTE_CR || b == BYTE_DEL)) begin
      advance(b);
    end
  endfunction

  function bit field_differs(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    return want !== got;
  endfunction

  function void check_result(result_t got);
    result_t want;
    bit bad;
    results_seen++;
    if (got.kind == KIND_ATTR) attr_seen++;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = expected_q.pop_front();
    bad = 1'b0;
    bad |= field_differs("kind", 8'(want.kind), 8'(got.kind));
    bad |= field_differs("out_byte", want.out_byte, got.out_byte);
    bad |= field_differs("fg_color", 8'(want.fg_color), 8'(got.fg_color));
    bad |= field_differs("bg_color", want.bg_color, got.bg_color);
    bad |= field_differs("fg_nondefault", 8'(want.fg_nondefault), 8'(got.fg_nondefault));
    bad |= field_differs("bg_nondefault", 8'(want.bg_nondefault), 8'(got.bg_nondefault));
    bad |= field_differs("last", 8'(want.last), 8'(got.last));
    if (bad) errors++;
  endfunction
endclass

module testbench;
  localparam int RANDOM_ITEMS = 550;
  localparam int IDLE_LIMIT   = 1000;
  localparam int LONG_HOLD    = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       kind;
  logic [7:0] out_byte;
  logic [4:0] fg_color;
  logic [7:0] bg_color;
  logic       fg_nondefault;
  logic       bg_nondefault;
  logic       last;

  colour_scoreboard sb = new();
  result_t seen;
  logic [7:0] stream[$];
  int in_gap_max = 5;
  int out_gap_max = 5;
  int hold_off = 0;
  int idle_cycles = 0;

  ansi_sgr_color_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .out_byte(out_byte), .fg_color(fg_color), .bg_color(bg_color),
    .fg_nondefault(fg_nondefault), .bg_nondefault(bg_nondefault), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_byte(in_byte);
    if (!rst && out_valid && out_ready) begin
      seen.kind = kind;
      seen.out_byte = out_byte;
      seen.fg_color = fg_color;
      seen.bg_color = bg_color;
      seen.fg_nondefault = fg_nondefault;
      seen.bg_nondefault = bg_nondefault;
      seen.last = last;
      sb.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : receiver
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (hold_off > 0) begin
        gap = hold_off;
        hold_off = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic void add_number(int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 5) == 0) stream.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) stream.push_back(8'(s[i]));
  endfunction

  function automatic void add_intro();
    if ($urandom_range(0, 1) == 0) begin
      stream.push_back(BYTE_ESC);
      stream.push_back(CH_LBRACKET);
    end else begin
      stream.push_back(BYTE_CSI);
    end
  endfunction

  function automatic void add_text(int n);
    for (int i = 0; i < n; i++) stream.push_back(8'($urandom_range(8'h20, 8'hFF)));
  endfunction

  function automatic void add_params();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) stream.push_back(CH_SEMI);
      case ($urandom_range(0, 7))
        0: add_number(int'(SGR_RESET));
        1: add_number(int'(SGR_BOLD));
        2, 3: add_number(int'(SGR_FG_BASE) + $urandom_range(0, 9));
        4, 5: add_number(int'(SGR_BG_BASE) + $urandom_range(0, 9));
        6: add_number($urandom_range(0, 255));
        default: begin
          if ($urandom_range(0, 1) == 0) add_number($urandom_range(256, 999));
        end
      endcase
    end
  endfunction

  function automatic void build_chunk();
    int sub;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        add_intro();
        add_params();
        stream.push_back(CH_M);
        add_text($urandom_range(1, 3));
      end
      4: add_text($urandom_range(1, 6));
      5: begin
        add_intro();
        sub = $urandom_range(0, 5);
        if (sub == 0) begin
          stream.push_back(CH_K);
        end else if (sub == 1) begin
          stream.push_back(CH_H);
        end else if (sub == 2) begin
          stream.push_back(CH_J);
        end else if (sub == 3) begin
          stream.push_back(CH_QUERY);
          stream.push_back(8'($urandom_range(0, 255)));
          stream.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else if (sub == 4) begin
          add_params();
          stream.push_back(CH_LBRACKET);
          stream.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else begin
          add_params();
          stream.push_back(8'($urandom_range(8'h40, 8'h7E)));
        end
        add_text($urandom_range(0, 2));
      end
      6: begin
        stream.push_back(BYTE_ESC);
        sub = $urandom_range(0, 3);
        if (sub == 0) stream.push_back(CH_EQ);
        else if (sub == 1) stream.push_back(CH_GT);
        else if (sub == 2) stream.push_back(CH_H);
        else begin
          add_text($urandom_range(1, 2));
          stream.push_back(CH_LBRACKET);
          add_params();
          stream.push_back(CH_M);
        end
        add_text($urandom_range(1, 2));
      end
      7: begin
        add_intro();
        add_params();
        case ($urandom_range(0, 9))
          0: stream.push_back(BYTE_CAN);
          1: stream.push_back(BYTE_SUB);
          2: stream.push_back(BYTE_ESC);
          3: stream.push_back(BYTE_CSI);
          4: stream.push_back(BYTE_NUL);
          5: stream.push_back(BYTE_BEL);
          6: stream.push_back(BYTE_VT);
          7: stream.push_back(BYTE_FF);
          8: stream.push_back(BYTE_CR);
          default: stream.push_back(BYTE_DEL);
        endcase
        if ($urandom_range(0, 1) == 0) add_params();
        stream.push_back(CH_M);
        add_text($urandom_range(1, 2));
      end
      default: begin
        sub = $urandom_range(1, 4);
        for (int i = 0; i < sub; i++) stream.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    bit held, drained;
    sent = 0;
    held = 1'b0;
    drained = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    stream = '{8'h41, BYTE_NUL, BYTE_BEL, BYTE_VT, BYTE_FF, BYTE_CR, BYTE_DEL,
               BYTE_ESC, CH_LBRACKET, 8'h31, CH_SEMI, 8'h33, 8'h31, CH_SEMI, 8'h34,
               8'h37, CH_M, 8'hFF, BYTE_ESC, BYTE_CAN, BYTE_CSI, 8'h39, 8'h39,
               8'h39, CH_M, 8'h80};
    while (stream.size() > 0) send_byte(stream.pop_front());

    while (sent < RANDOM_ITEMS) begin
      if (sent >= 150 && !held) begin
        hold_off = LONG_HOLD;
        held = 1'b1;
      end
      if (sent >= 250 && sent < 350) begin
        in_gap_max = 0;
        out_gap_max = 0;
      end else begin
        in_gap_max = 5;
        out_gap_max = 5;
      end
      if (sent >= 420 && !drained) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_count() != 0) @(posedge clk);
        drained = 1'b1;
      end
      build_chunk();
      while (stream.size() > 0) begin
        send_byte(stream.pop_front());
        sent++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes and checked %0d results, %0d of them attribute changes.",
             sb.bytes_seen, sb.results_seen, sb.attr_seen);
    $display("Run covered SGR colours, saturation, aborts, a long output stall and a drain.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/asgr_pkg.sv
hw/rtl/asgr_parser.sv
hw/rtl/asgr_out_fifo.sv
hw/rtl/ansi_sgr_color_parser.sv
bench/testbench.sv
